// File: rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types and the utf-8 encoder for the utf-16 to utf-8 transcoder
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

  localparam logic [20:0] REPL_CP    = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [5:0]  LEAD_TAG   = 6'b110110;
  localparam logic [5:0]  TRAIL_TAG  = 6'b110111;

  // one encoded scalar: up to four bytes, byte 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            repl;
  } seg_t;

  // everything one request produces; seg0 is never empty when queued
  typedef struct packed {
    seg_t seg0;
    seg_t seg1;
    logic has_seg1;
    logic last;
    logic ok;
  } rec_t;

  localparam seg_t SEG_EMPTY = '{bytes: '0, len: 3'd0, repl: 1'b0};

  function automatic seg_t encode(input logic [20:0] cp, input logic repl);
    seg_t s;
    s = SEG_EMPTY;
    s.repl = repl;
    if (cp < 21'h80) begin
      s.len = 3'd1;
      s.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      s.len = 3'd2;
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      s.len = 3'd3;
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      s.len = 3'd4;
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, pairs surrogates, builds the byte record for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  output logic             push,
  input  wire logic        push_ready,
  output rec_t             push_rec
);

  logic [9:0] held_lead_bits, held_lead_bits_next;
  logic       held_lead_valid, held_lead_valid_next;
  logic       error_seen, error_seen_next;

  logic       is_lead, is_trail, fresh, hold, accept, err_item;
  seg_t       seg_a, seg_b;
  logic [20:0] pair_cp;

  assign is_lead  = (code_unit[15:10] == LEAD_TAG);
  assign is_trail = (code_unit[15:10] == TRAIL_TAG);
  assign pair_cp  = SUPP_BASE + {1'b0, held_lead_bits, code_unit[9:0]};
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    seg_a = SEG_EMPTY;
    seg_b = SEG_EMPTY;
    fresh = 1'b1;
    hold  = 1'b0;
    if (held_lead_valid) begin
      if (is_trail) begin
        seg_a = encode(pair_cp, 1'b0);
        fresh = 1'b0;
      end else begin
        seg_a = encode(REPL_CP, 1'b1);
      end
    end
    if (fresh) begin
      if (is_lead) begin
        if (last_unit) begin
          seg_b = encode(REPL_CP, 1'b1);
        end else begin
          hold = 1'b1;
        end
      end else if (is_trail) begin
        seg_b = encode(REPL_CP, 1'b1);
      end else begin
        seg_b = encode({5'd0, code_unit}, 1'b0);
      end
    end
    err_item = seg_a.repl || seg_b.repl;
  end

  always_comb begin
    push_rec.last = last_unit;
    push_rec.ok   = !(error_seen || err_item);
    if (seg_a.len == 3'd0) begin
      push_rec.seg0     = seg_b;
      push_rec.seg1     = SEG_EMPTY;
      push_rec.has_seg1 = 1'b0;
    end else begin
      push_rec.seg0     = seg_a;
      push_rec.seg1     = seg_b;
      push_rec.has_seg1 = (seg_b.len != 3'd0);
    end
    push = in_valid && (push_rec.seg0.len != 3'd0);
  end

  always_comb begin
    held_lead_bits_next  = held_lead_bits;
    held_lead_valid_next = held_lead_valid;
    error_seen_next      = error_seen;
    if (accept) begin
      if (last_unit) begin
        held_lead_bits_next  = '0;
        held_lead_valid_next = 1'b0;
        error_seen_next      = 1'b0;
      end else begin
        held_lead_valid_next = hold;
        if (hold) begin
          held_lead_bits_next = code_unit[9:0];
        end
        error_seen_next = error_seen || err_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead_bits  <= '0;
      held_lead_valid <= 1'b0;
      error_seen      <= 1'b0;
    end else begin
      held_lead_bits  <= held_lead_bits_next;
      held_lead_valid <= held_lead_valid_next;
      error_seen      <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// small record queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire rec_t wr_rec,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output rec_t      rd_rec
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          do_wr, do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_rec   = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_wr) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_next = count + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// walks the head record, one utf-8 byte per cycle while rd_valid && out_ready
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  rd_valid,
  output logic       rd_ready,
  input  wire rec_t  rd_rec,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       replaced,
  output logic       end_of_string,
  output logic       string_ok
);

  logic       seg_sel, seg_sel_next;
  logic [1:0] byte_idx, byte_idx_next;
  seg_t       cur_seg;
  logic       last_in_seg, last_in_rec, take;

  assign cur_seg     = seg_sel ? rd_rec.seg1 : rd_rec.seg0;
  assign last_in_seg = ({1'b0, byte_idx} == (cur_seg.len - 3'd1));
  assign last_in_rec = last_in_seg && (seg_sel || !rd_rec.has_seg1);
  assign take        = rd_valid && out_ready;

  assign out_valid     = rd_valid;
  assign out_byte      = cur_seg.bytes[byte_idx];
  assign replaced      = cur_seg.repl;
  assign last_of_run   = last_in_rec;
  assign end_of_string = last_in_rec && rd_rec.last;
  assign string_ok     = last_in_rec && rd_rec.last && rd_rec.ok;
  assign rd_ready      = out_ready && last_in_rec;

  always_comb begin
    seg_sel_next  = seg_sel;
    byte_idx_next = byte_idx;
    if (take) begin
      if (last_in_rec) begin
        seg_sel_next  = 1'b0;
        byte_idx_next = '0;
      end else if (last_in_seg) begin
        seg_sel_next  = 1'b1;
        byte_idx_next = '0;
      end else begin
        byte_idx_next = byte_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_sel  <= 1'b0;
      byte_idx <= '0;
    end else begin
      seg_sel  <= seg_sel_next;
      byte_idx <= byte_idx_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf16_to_utf8_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// utf-16 code units in, utf-8 bytes out, with u+fffd for ill-formed units
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   in       in_valid / in_ready   code_unit[15:0], last_unit
//   out      out_valid / out_ready out_byte[7:0], last_of_run, replaced,
//                                  end_of_string, string_ok
//
// one output byte per cycle while out_ready is high; a request makes 1 to 6 bytes
// (3 for typical non-ascii bmp text); a held lead makes none
// the byte serializer in the back end sets the output rate
// the front takes a request in the same cycle it arrives while the queue has room
// rst is synchronous; no clearing pass, the block is ready the cycle after reset
// a stalled output holds the queue head, the front keeps filling the queue
//
`default_nettype none

module utf16_to_utf8_transcoder_core
  import u16u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             replaced,
  output logic             end_of_string,
  output logic             string_ok
);

  // front to queue
  logic push, push_ready;
  rec_t push_rec;

  // queue to back
  logic head_valid, head_ready;
  rec_t head_rec;

  // surrogate pairing, error tracking and encoding
  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_unit  (code_unit),
    .last_unit  (last_unit),
    .push       (push),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  // decouples request intake from byte output
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_rec   (push_rec),
    .rd_valid (head_valid),
    .rd_ready (head_ready),
    .rd_rec   (head_rec)
  );

  // byte serializer
  u16u8_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rd_valid      (head_valid),
    .rd_ready      (head_ready),
    .rd_rec        (head_rec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .replaced      (replaced),
    .end_of_string (end_of_string),
    .string_ok     (string_ok)
  );

  // end of string only ever lands on the last byte of a request
  a_eos_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> last_of_run)
    else $error("end_of_string without last_of_run");

  // success flag only rides on the end of string byte
  a_ok_on_eos: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_ok |-> end_of_string)
    else $error("string_ok away from end of string");

  // every byte of ef bf bd has its top bit set
  a_repl_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced |-> out_byte[7])
    else $error("replacement byte below 0x80");

  // a replaced byte at the end of string must report failure
  a_repl_not_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced && end_of_string |-> !string_ok)
    else $error("string_ok set on replaced byte");

endmodule

`default_nettype wire

// File: verif/utf16_to_utf8_transcoder_core_test.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core_test
// self-checking bench: utf-16 units go in under random idling and long
// output stalls, every utf-8 byte out is compared with a local transcoder
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_core_test;

  // watchdog limit, set generously above real traffic
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 250;

  // u+fffd code point, encoded as ef bf bd
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;

  // one expected output byte with its side flags
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       repl;
    logic       eos;
    logic       ok;
  } utf8_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit = '0;
  logic        last_unit = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        replaced;
  logic        end_of_string;
  logic        string_ok;

  // bytes still owed by the block, oldest first
  utf8_byte_t expected_bytes[$];

  // transcoder state mirrored on the bench side
  logic [9:0] pend_lead_bits = '0;
  logic       pend_lead = 1'b0;
  logic       str_err = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_id = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int units_sent = 0;

  utf16_to_utf8_transcoder_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_unit    (code_unit),
    .last_unit    (last_unit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .replaced     (replaced),
    .end_of_string(end_of_string),
    .string_ok    (string_ok)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // local transcoder
  // ---------------------------------------------------------------------------

  // utf-8 bytes of one scalar, appended to the bytes of this request
  function automatic void encode_scalar(input logic [20:0] cp, input logic repl,
                                        ref utf8_byte_t run[$]);
    utf8_byte_t b;
    b = '0;
    b.repl = repl;
    if (cp < 21'h80) begin
      b.data = {1'b0, cp[6:0]};
      run.push_back(b);
    end else if (cp < 21'h800) begin
      b.data = {3'b110, cp[10:6]};
      run.push_back(b);
      b.data = {2'b10, cp[5:0]};
      run.push_back(b);
    end else if (cp < 21'h10000) begin
      b.data = {4'b1110, cp[15:12]};
      run.push_back(b);
      b.data = {2'b10, cp[11:6]};
      run.push_back(b);
      b.data = {2'b10, cp[5:0]};
      run.push_back(b);
    end else begin
      b.data = {5'b11110, cp[20:18]};
      run.push_back(b);
      b.data = {2'b10, cp[17:12]};
      run.push_back(b);
      b.data = {2'b10, cp[11:6]};
      run.push_back(b);
      b.data = {2'b10, cp[5:0]};
      run.push_back(b);
    end
  endfunction

  // one accepted request: update the mirrored state, queue the bytes it makes
  function automatic void transcode_unit(input logic [15:0] cu, input logic last);
    utf8_byte_t run[$];
    logic       is_lead;
    logic       is_trail;
    logic       fresh;
    logic [20:0] cp;
    is_lead  = (cu[15:10] == 6'b110110);
    is_trail = (cu[15:10] == 6'b110111);
    fresh    = 1'b1;
    if (pend_lead) begin
      pend_lead = 1'b0;
      if (is_trail) begin
        cp = 21'h10000 + {1'b0, pend_lead_bits, cu[9:0]};
        encode_scalar(cp, 1'b0, run);
        fresh = 1'b0;
      end else begin
        // lead then non-trail: the held lead turns into a replacement
        str_err = 1'b1;
        encode_scalar({5'd0, REPLACEMENT}, 1'b1, run);
      end
    end
    if (fresh) begin
      if (is_lead) begin
        if (last) begin
          // lead as the final unit is never held
          str_err = 1'b1;
          encode_scalar({5'd0, REPLACEMENT}, 1'b1, run);
        end else begin
          pend_lead_bits = cu[9:0];
          pend_lead      = 1'b1;
        end
      end else if (is_trail) begin
        str_err = 1'b1;
        encode_scalar({5'd0, REPLACEMENT}, 1'b1, run);
      end else begin
        encode_scalar({5'd0, cu}, 1'b0, run);
      end
    end
    if (run.size() > 0) begin
      run[run.size()-1].run_end = 1'b1;
      if (last) begin
        run[run.size()-1].eos = 1'b1;
        run[run.size()-1].ok  = ~str_err;
      end
    end
    if (last) begin
      pend_lead      = 1'b0;
      pend_lead_bits = '0;
      str_err        = 1'b0;
    end
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: both handshakes seen at the same edge, request side first, so a
  // same-cycle result can never outrun its prediction
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    utf8_byte_t exp_b;
    if (!rst) begin
      if (in_valid && in_ready) transcode_unit(code_unit, last_unit);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %02h", $time, out_byte);
          fail_count++;
        end else begin
          exp_b = expected_bytes.pop_front();
          check_field("out_byte", exp_b.data, out_byte);
          check_field("last_of_run", exp_b.run_end, last_of_run);
          check_field("replaced", exp_b.repl, replaced);
          check_field("end_of_string", exp_b.eos, end_of_string);
          check_field("string_ok", exp_b.ok, string_ok);
        end
      end
    end
  end

  // receiver: random ready, or a long hold-off when the test asks for one
  always @(posedge clk) begin
    int hold_seen;
    int stall_left;
    if (hold_id != hold_seen) begin
      hold_seen  = hold_id;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request and hold it until taken; valid stays high on return so
  // a back-to-back request needs no second assignment in the same step
  task automatic send_unit(input logic [15:0] cu, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= cu;
    last_unit <= last;
    do @(posedge clk); while (!in_ready);
    units_sent++;
  endtask

  // sender pause: nothing offered until every owed byte is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // one random scalar as one or two units
  task automatic pick_scalar(ref logic [15:0] units[$], input bit noisy);
    int sel;
    sel = $urandom_range(99);
    if (noisy && $urandom_range(99) < 35) begin
      // noise: raw value, lone lead or lone trail
      case ($urandom_range(2))
        0: units.push_back(16'($urandom()));
        1: units.push_back(16'hD800 | 16'($urandom_range(1023)));
        default: units.push_back(16'hDC00 | 16'($urandom_range(1023)));
      endcase
    end else if (sel < 25) begin
      units.push_back(16'($urandom_range(16'h007F)));
    end else if (sel < 40) begin
      units.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
    end else if (sel < 50) begin
      units.push_back(16'($urandom_range(16'hD7FF, 16'h0800)));
    end else if (sel < 60) begin
      units.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
    end else begin
      units.push_back(16'hD800 | 16'($urandom_range(1023)));
      units.push_back(16'hDC00 | 16'($urandom_range(1023)));
    end
  endtask

  // one random string, mostly well formed
  task automatic send_random_string();
    logic [15:0] units[$];
    bit          noisy;
    int          n_scalars;
    noisy     = ($urandom_range(99) < 20);
    n_scalars = $urandom_range(5, 1);
    repeat (n_scalars) pick_scalar(units, noisy);
    foreach (units[i]) send_unit(units[i], i == units.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every length boundary of the bmp, both sides of the surrogate gap
  task automatic test_bmp_boundaries();
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(REPLACEMENT, 1'b0);
    send_unit(16'hFFFF, 1'b1);
  endtask

  // lowest and highest supplementary scalars, pair closing a string
  task automatic test_surrogate_pairs();
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b1);
  endtask

  task automatic test_ill_formed();
    // lead then non-trail, the non-trail handled afresh
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h0041, 1'b0);
    // lone trail
    send_unit(16'hDC00, 1'b0);
    // lead then lead then trail
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC02, 1'b0);
    // held lead, then a lead as the final unit: two replacements at once
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    // clean string right after a broken one must report ok
    send_unit(16'h0061, 1'b1);
    // single-unit strings: lone trail, lone lead; then a lead before a final bmp unit
    send_unit(16'hDC00, 1'b1);
    send_unit(16'hD800, 1'b1);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h00E9, 1'b1);
  endtask

  task automatic test_random_strings(input int n_units);
    int stop_at;
    stop_at = units_sent + n_units;
    while (units_sent < stop_at) send_random_string();
  endtask

  // output held off for a long stretch while requests keep coming, so the
  // queue fills and the input stalls; then the sender pauses until drained
  task automatic test_backpressure();
    hold_id++;
    repeat (12) send_unit(16'($urandom_range(16'hD7FF, 16'h0800)), 1'b0);
    send_unit(16'h20AC, 1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(37, 73);
    test_bmp_boundaries();
    test_surrogate_pairs();
    test_ill_formed();
    wait_drained();
    test_random_strings(22);

    set_idling(73, 37);
    test_random_strings(22);
    wait_drained();

    set_idling(0, 0);
    test_backpressure();
    test_random_strings(22);

    wait_drained();
    if (expected_bytes.size() != 0) begin
      $display("%0t: bytes left over, expected 0, actual %0d", $time, expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
